// ===== src/npc_pkg.sv =====
// Shared types, constants and the microcode program of the nearest palette color search.
// Used by npc_seq, nearest_palette_color_top and npc_checker.
package npc_pkg;

	localparam int          PC_W      = 2;
	localparam logic [17:0] INIT_DIST = 18'd198147;   // 3 * 257 * 257
	localparam logic        REQ_WRITE = 1'b0;
	localparam logic        REQ_QUERY = 1'b1;

	// jump conditions: jump to target when true, else fall through to pc + 1
	localparam logic [1:0] JC_NEVER       = 2'd0;
	localparam logic [1:0] JC_NO_QUERY    = 2'd1;
	localparam logic [1:0] JC_SCAN_MORE   = 2'd2;
	localparam logic [1:0] JC_OUT_BLOCKED = 2'd3;

	// program steps
	localparam logic [PC_W-1:0] PC_WAIT  = 2'd0;
	localparam logic [PC_W-1:0] PC_SCAN  = 2'd1;
	localparam logic [PC_W-1:0] PC_DRAIN = 2'd2;
	localparam logic [PC_W-1:0] PC_EMIT  = 2'd3;

	typedef struct packed {
		logic            in_ready;
		logic            scan_en;
		logic            emit_en;
		logic [1:0]      jcond;
		logic [PC_W-1:0] target;
	} ctrl_word_t;

	typedef struct packed {
		logic acc_query;
		logic scan_more;
		logic out_blocked;
	} seq_status_t;

	function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
		ctrl_word_t w;
		w = '0;
		unique case (pc)
			PC_WAIT: begin
				w.in_ready = 1'b1;
				w.jcond    = JC_NO_QUERY;
				w.target   = PC_WAIT;
			end
			PC_SCAN: begin
				w.scan_en = 1'b1;
				w.jcond   = JC_SCAN_MORE;
				w.target  = PC_SCAN;
			end
			PC_DRAIN: begin
				w.jcond  = JC_NEVER;
				w.target = PC_DRAIN;
			end
			PC_EMIT: begin
				// falls through to pc + 1, which wraps to the wait step
				w.emit_en = 1'b1;
				w.jcond   = JC_OUT_BLOCKED;
				w.target  = PC_EMIT;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== src/npc_seq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on npc_pkg.
module npc_seq import npc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  seq_status_t status,
	output ctrl_word_t  ctrl
);

	logic [PC_W-1:0] pc_q;
	logic            taken;

	assign ctrl = ucode(pc_q);

	always_comb begin
		unique case (ctrl.jcond)
			JC_NEVER:       taken = 1'b0;
			JC_NO_QUERY:    taken = !status.acc_query;
			JC_SCAN_MORE:   taken = status.scan_more;
			JC_OUT_BLOCKED: taken = status.out_blocked;
			default:        taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else if (taken) begin
			pc_q <= ctrl.target;
		end else begin
			pc_q <= pc_q + PC_W'(1);
		end
	end

endmodule

// ===== src/nearest_palette_color_top.sv =====
// Nearest palette color search: palette memory, scan datapath and output register.
// Depends on npc_pkg and npc_seq.
//
// Usage:
//   Input channel (in_valid/in_ready) carries two kinds of transaction. A write
//   (req_type = 0) stores red/green/blue at entry_index; it
//   gives no result. A query (req_type = 1) scans palette entries search_first up
//   to search_end - 1 and returns one result on the output channel
//   (out_valid/out_ready): best_index, best_distance, exact_hit.
//   A query's result shows once the scan of its entries has drained, earlier when
//   an exact match ends the scan; in_ready returns in the same cycle, so the block
//   takes no new transaction while a query is in progress. The scan rate of one
//   entry per cycle is set by the single read port of the palette memory, feeding
//   a two-stage distance pipeline.
//   Result is held in an output register; the block takes writes and a new query
//   while it waits, and only stalls at the end of that next query until the
//   receiver takes the pending result.
//   Reset clears the control state; palette contents stay undefined until written.
module nearest_palette_color_top import npc_pkg::*; #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  entry_index,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [7:0]  search_first,
	input  logic [8:0]  search_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  best_index,
	output logic [17:0] best_distance,
	output logic        exact_hit
);

	localparam int AW       = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam int SCAN_CAP = (PALETTE_ENTRIES > 256) ? 256 : PALETTE_ENTRIES;
	localparam logic [12:0] DEPTH13 = 13'(PALETTE_ENTRIES);
	localparam logic [8:0]  CAP9    = 9'(SCAN_CAP);

	ctrl_word_t  ctrl;
	seq_status_t status;

	logic        accept;
	logic        acc_query;
	logic        mem_we;
	logic        mem_re;
	logic        emit;
	logic [12:0] wr_ext;
	logic [12:0] rd_ext;
	logic [8:0]  lim;

	logic [23:0] pal_mem [PALETTE_ENTRIES];

	// query and scan state
	logic [7:0]  qr_q, qg_q, qb_q;
	logic [8:0]  cur_q;
	logic [8:0]  lim_q;
	logic [7:0]  best_idx_q;
	logic [17:0] best_dist_q;
	logic        hit_q;

	// scan pipeline
	logic        v_s1;
	logic [7:0]  idx_s1;
	logic [23:0] rd_data_s1;
	logic        v_s2;
	logic [7:0]  idx_s2;
	logic [17:0] d_s2;

	logic [7:0]  dr, dg, db;
	logic [15:0] sqr, sqg, sqb;
	logic        better;

	// output register
	logic        out_valid_q;
	logic [7:0]  out_idx_q;
	logic [17:0] out_dist_q;
	logic        out_hit_q;

	npc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	assign in_ready  = ctrl.in_ready;
	assign accept    = in_valid && in_ready;
	assign acc_query = accept && (req_type == REQ_QUERY);
	assign wr_ext    = {5'b0, entry_index};
	assign mem_we    = accept && (req_type == REQ_WRITE) && (wr_ext < DEPTH13);
	assign mem_re    = ctrl.scan_en && (cur_q < lim_q) && !hit_q;
	assign rd_ext    = {4'b0, cur_q};
	assign lim       = (search_end > CAP9) ? CAP9 : search_end;

	assign status.acc_query   = acc_query;
	assign status.scan_more   = (cur_q < lim_q) && !hit_q;
	assign status.out_blocked = out_valid_q && !out_ready;
	assign emit               = ctrl.emit_en && !status.out_blocked;

	// single port: writes only in the wait step, reads only in the scan step
	always_ff @(posedge clk) begin
		if (mem_we) begin
			pal_mem[wr_ext[AW-1:0]] <= {red, green, blue};
		end
		if (mem_re) begin
			rd_data_s1 <= pal_mem[rd_ext[AW-1:0]];
		end
	end

	always_comb begin
		dr  = (qr_q > rd_data_s1[23:16]) ? qr_q - rd_data_s1[23:16] : rd_data_s1[23:16] - qr_q;
		dg  = (qg_q > rd_data_s1[15:8])  ? qg_q - rd_data_s1[15:8]  : rd_data_s1[15:8] - qg_q;
		db  = (qb_q > rd_data_s1[7:0])   ? qb_q - rd_data_s1[7:0]   : rd_data_s1[7:0] - qb_q;
		sqr = 16'(dr) * 16'(dr);
		sqg = 16'(dg) * 16'(dg);
		sqb = 16'(db) * 16'(db);
	end

	// entries still in flight after an exact hit are dropped
	assign better = v_s2 && !hit_q && (d_s2 < best_dist_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= mem_re;
			v_s2 <= v_s1;
			if (acc_query) begin
				hit_q <= 1'b0;
			end else if (better && (d_s2 == 18'd0)) begin
				hit_q <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cur_q[7:0];
		idx_s2 <= idx_s1;
		d_s2   <= 18'(sqr) + 18'(sqg) + 18'(sqb);
		if (acc_query) begin
			qr_q        <= red;
			qg_q        <= green;
			qb_q        <= blue;
			cur_q       <= {1'b0, search_first};
			lim_q       <= lim;
			best_idx_q  <= search_first;
			best_dist_q <= INIT_DIST;
		end else begin
			if (mem_re) begin
				cur_q <= cur_q + 9'd1;
			end
			if (better) begin
				best_idx_q  <= idx_s2;
				best_dist_q <= d_s2;
			end
		end
		if (emit) begin
			out_idx_q  <= best_idx_q;
			out_dist_q <= best_dist_q;
			out_hit_q  <= hit_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign best_index    = out_idx_q;
	assign best_distance = out_dist_q;
	assign exact_hit     = out_hit_q;

endmodule

// ===== src/npc_checker.sv =====
// Port-level checks for nearest_palette_color_top, attached by bind.
// Depends on npc_pkg.
module npc_checker import npc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        req_type,
	input logic        out_valid,
	input logic        out_ready,
	input logic [17:0] best_distance,
	input logic        exact_hit
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_hit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (exact_hit == (best_distance == 18'd0)))
		else $error("exact_hit disagrees with distance");

	a_dist_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (best_distance <= INIT_DIST))
		else $error("distance above initial value");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (req_type == REQ_QUERY) |=> !in_ready)
		else $error("ready during query scan");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (req_type == REQ_WRITE) |=> !$rose(out_valid))
		else $error("write transaction produced a result");

endmodule

bind nearest_palette_color_top npc_checker u_npc_checker (.*);
